// ===== rtl/core/dlct_pkg.sv =====
// Shared types, constants and helper functions of the daily level consumption tracker.
// The interfaces, the update and the top refer to this package by scoped names.
`default_nettype none
package dlct_pkg;

	localparam int NumKegs   = 4;
	localparam int KegW      = 2;
	localparam int HistDepth = 62;
	localparam int CntW      = 6;
	localparam int ArchDepth = NumKegs * HistDepth;
	localparam int ArchAw    = $clog2(ArchDepth);

	localparam int ActW    = 2;
	localparam int LevelW  = 16;
	localparam int WeightW = 18;
	localparam int DayW    = 27;
	localparam int PosW    = 6;

	localparam int NoiseW  = 10;
	localparam int RemW    = 13;
	localparam int RetW    = 10;
	localparam int HystW   = 10;
	localparam int MarginW = 14;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 14;

	localparam logic [ActW-1:0] ActSample = 2'd0;
	localparam logic [ActW-1:0] ActReset  = 2'd1;
	localparam logic [ActW-1:0] ActRead   = 2'd2;

	localparam logic [CfgIdxW-1:0] RegNoise  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegRemove = 3'd1;
	localparam logic [CfgIdxW-1:0] RegReturn = 3'd2;
	localparam logic [CfgIdxW-1:0] RegHyst   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegMargin = 3'd4;

	typedef struct packed {
		logic [NoiseW-1:0]  noise_tolerance_cl;
		logic [RemW-1:0]    removal_drop_cl;
		logic [RetW-1:0]    return_tolerance_cl;
		logic [HystW-1:0]   rise_hysteresis_cl;
		logic [MarginW-1:0] weight_margin_g;
	} cfg_t;

	typedef struct packed {
		logic [ActW-1:0]    action;
		logic [KegW-1:0]    keg_index;
		logic [LevelW-1:0]  level_cl;
		logic [WeightW-1:0] weight_g;
		logic [WeightW-1:0] empty_weight_g;
		logic               scale_ok;
		logic [DayW-1:0]    day_number;
		logic [PosW-1:0]    position;
	} item_t;

	typedef struct packed {
		logic [LevelW-1:0] consumption_cl;
		logic              is_suspended;
		logic              is_initialized;
		logic              archived;
		logic [DayW-1:0]   archived_day;
		logic [LevelW-1:0] archived_cl;
		logic [CntW-1:0]   history_count;
		logic              record_valid;
		logic [DayW-1:0]   record_day;
		logic [LevelW-1:0] record_cl;
	} result_t;

	// Per-container word of the state memory. The newest archived day is kept here so
	// that a day change needs no archive read.
	typedef struct packed {
		logic              tracked;
		logic              suspended;
		logic [LevelW-1:0] day_max;
		logic [LevelW-1:0] last_level;
		logic [DayW-1:0]   tracked_day;
		logic [DayW-1:0]   newest_day;
		logic [CntW-1:0]   count;
		logic [CntW-1:0]   head;
	} keg_state_t;

	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [LevelW-1:0] amount;
	} arc_entry_t;

	typedef struct packed {
		keg_state_t        next;
		logic              in_range;
		logic              archived;
		logic              arc_we;
		logic              arc_re;
		logic [ArchAw-1:0] arc_addr;
		arc_entry_t        arc_wdata;
	} upd_t;

	localparam int KegStW = $bits(keg_state_t);
	localparam int ArcW   = $bits(arc_entry_t);

	function automatic logic [LevelW-1:0] usage_at(
		input logic [LevelW-1:0] day_max,
		input logic [LevelW-1:0] level,
		input logic [NoiseW-1:0] noise
	);
		logic [LevelW-1:0] drop;
		drop = (day_max > level) ? day_max - level : '0;
		return (drop >= LevelW'(noise)) ? drop : '0;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dlct_ifs.sv =====
// Handshake interfaces of the tracker: the item channel and the result channel.
// Field types come from dlct_pkg.
`default_nettype none
interface dlct_req_if;
	logic                           valid;
	logic                           ready;
	logic [dlct_pkg::ActW-1:0]      action;
	logic [dlct_pkg::KegW-1:0]      keg_index;
	logic [dlct_pkg::LevelW-1:0]    level_cl;
	logic [dlct_pkg::WeightW-1:0]   weight_g;
	logic [dlct_pkg::WeightW-1:0]   empty_weight_g;
	logic                           scale_ok;
	logic [dlct_pkg::DayW-1:0]      day_number;
	logic [dlct_pkg::PosW-1:0]      position;

	modport source (output valid, action, keg_index, level_cl, weight_g, empty_weight_g,
		scale_ok, day_number, position, input ready);
	modport sink (input valid, action, keg_index, level_cl, weight_g, empty_weight_g,
		scale_ok, day_number, position, output ready);
endinterface

interface dlct_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [dlct_pkg::LevelW-1:0]    consumption_cl;
	logic                           is_suspended;
	logic                           is_initialized;
	logic                           archived;
	logic [dlct_pkg::DayW-1:0]      archived_day;
	logic [dlct_pkg::LevelW-1:0]    archived_cl;
	logic [dlct_pkg::CntW-1:0]      history_count;
	logic                           record_valid;
	logic [dlct_pkg::DayW-1:0]      record_day;
	logic [dlct_pkg::LevelW-1:0]    record_cl;

	modport source (output valid, consumption_cl, is_suspended, is_initialized, archived,
		archived_day, archived_cl, history_count, record_valid, record_day, record_cl,
		input ready);
	modport sink (input valid, consumption_cl, is_suspended, is_initialized, archived,
		archived_day, archived_cl, history_count, record_valid, record_day, record_cl,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dlct_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module dlct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/dlct_keg_update.sv =====
// Per-container update: next state, archive write or read request for one item.
// Uses types and constants of dlct_pkg.
`default_nettype none
module dlct_keg_update (
	input  wire dlct_pkg::item_t      item,
	input  wire dlct_pkg::keg_state_t cur,
	input  wire dlct_pkg::cfg_t       cfg,
	output dlct_pkg::upd_t            upd
);
	function automatic dlct_pkg::keg_state_t start_day(
		input dlct_pkg::keg_state_t st,
		input logic [dlct_pkg::DayW-1:0] day,
		input logic [dlct_pkg::LevelW-1:0] level
	);
		dlct_pkg::keg_state_t r;
		r = st;
		r.tracked     = 1'b1;
		r.suspended   = 1'b0;
		r.tracked_day = day;
		r.day_max     = level;
		r.last_level  = level;
		return r;
	endfunction

	logic                         removed;
	logic                         overwrite;
	logic                         full;
	logic [dlct_pkg::LevelW:0]    lvl_ret;
	logic [dlct_pkg::LevelW:0]    lvl_rem;
	logic [dlct_pkg::LevelW:0]    max_hyst;
	logic [dlct_pkg::LevelW-1:0]  amt;
	logic [dlct_pkg::CntW-1:0]    head_inc;
	logic [dlct_pkg::CntW-1:0]    hd;
	logic [dlct_pkg::CntW-1:0]    off;
	logic [dlct_pkg::CntW:0]      sum;
	logic [dlct_pkg::CntW:0]      wrapped;

	always_comb begin
		removed = ({1'b0, item.weight_g} + (dlct_pkg::WeightW + 1)'(cfg.weight_margin_g))
			< {1'b0, item.empty_weight_g};
		lvl_ret  = {1'b0, item.level_cl} + (dlct_pkg::LevelW + 1)'(cfg.return_tolerance_cl);
		lvl_rem  = {1'b0, item.level_cl} + (dlct_pkg::LevelW + 1)'(cfg.removal_drop_cl);
		max_hyst = {1'b0, cur.day_max} + (dlct_pkg::LevelW + 1)'(cfg.rise_hysteresis_cl);
		amt      = dlct_pkg::usage_at(cur.day_max, item.level_cl, cfg.noise_tolerance_cl);

		overwrite = (cur.count != '0) && (cur.newest_day == cur.tracked_day);
		full      = cur.count >= dlct_pkg::CntW'(dlct_pkg::HistDepth);
		head_inc  = (cur.head == dlct_pkg::CntW'(dlct_pkg::HistDepth - 1)) ?
			'0 : cur.head + 1'b1;

		// Ring slot: record read, newest entry, next free entry, or oldest when full.
		if (item.action == dlct_pkg::ActRead) begin
			hd  = cur.head;
			off = item.position;
		end else if (overwrite) begin
			hd  = cur.head;
			off = cur.count - 1'b1;
		end else if (full) begin
			hd  = head_inc;
			off = dlct_pkg::CntW'(dlct_pkg::HistDepth - 1);
		end else begin
			hd  = cur.head;
			off = cur.count;
		end
		sum     = {1'b0, hd} + {1'b0, off};
		wrapped = (sum >= (dlct_pkg::CntW + 1)'(dlct_pkg::HistDepth)) ?
			sum - (dlct_pkg::CntW + 1)'(dlct_pkg::HistDepth) : sum;

		upd           = '0;
		upd.next      = cur;
		upd.in_range  = {1'b0, item.keg_index} < (dlct_pkg::KegW + 1)'(dlct_pkg::NumKegs);
		upd.arc_addr  = dlct_pkg::ArchAw'(item.keg_index) * dlct_pkg::ArchAw'(dlct_pkg::HistDepth)
			+ dlct_pkg::ArchAw'(wrapped);
		upd.arc_wdata = '{day: cur.tracked_day, amount: amt};

		case (item.action)
			dlct_pkg::ActSample: begin
				if (item.day_number != '0 && item.scale_ok) begin
					if (removed) begin
						upd.next.suspended = 1'b1;
					end else if (!cur.tracked) begin
						upd.next = start_day(cur, item.day_number, item.level_cl);
					end else if (cur.tracked_day != item.day_number) begin
						if (cur.tracked_day != '0) begin
							upd.arc_we          = 1'b1;
							upd.archived        = 1'b1;
							upd.next.newest_day = cur.tracked_day;
							if (!overwrite) begin
								if (full) begin
									upd.next.head  = head_inc;
									upd.next.count = dlct_pkg::CntW'(dlct_pkg::HistDepth);
								end else begin
									upd.next.count = cur.count + 1'b1;
								end
							end
						end
						upd.next.tracked     = 1'b1;
						upd.next.suspended   = 1'b0;
						upd.next.tracked_day = item.day_number;
						upd.next.day_max     = item.level_cl;
						upd.next.last_level  = item.level_cl;
					end else if (cur.suspended) begin
						if (lvl_ret >= {1'b0, cur.last_level}) begin
							upd.next.suspended  = 1'b0;
							upd.next.last_level = item.level_cl;
						end
					end else if ({1'b0, cur.last_level} > lvl_rem) begin
						upd.next.suspended = 1'b1;
					end else begin
						upd.next.last_level = item.level_cl;
						if ({1'b0, item.level_cl} > max_hyst) begin
							upd.next.day_max = item.level_cl;
						end
					end
				end
			end
			dlct_pkg::ActReset: begin
				upd.next         = start_day(cur, item.day_number, item.level_cl);
				upd.next.tracked = item.day_number != '0;
			end
			dlct_pkg::ActRead: begin
				upd.arc_re = item.position < cur.count;
			end
			default: begin
			end
		endcase

		if (!upd.in_range) begin
			upd.next     = cur;
			upd.arc_we   = 1'b0;
			upd.arc_re   = 1'b0;
			upd.archived = 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/daily_level_consumption_tracker.sv =====
// Channel  Dir  Handshake      Contents
// req      in   valid/ready    action, keg_index, level, weights, scale_ok, day, position
// rsp      out  valid/ready    consumption, status, archived entry, history count, record
// cfg      in   cfg_we         cfg_index selects the register, cfg_wdata carries the value
//
// One item per cycle is taken unless rsp stalls; rsp carries the registered result.
// Container state sits in a four-word RAM read at transfer; an item that follows one for
// the same container takes the updated state forwarded from the first pipeline stage.
// The archive RAM is written or read in that stage and its read data used in the second.
// Reset clears valid flags and four per-container valid bits; there is no clearing pass.
// A stalled rsp holds the output register, then the stages behind it, then req.ready.
`default_nettype none
module daily_level_consumption_tracker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [dlct_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [dlct_pkg::CfgDataW-1:0] cfg_wdata,
	dlct_req_if.sink                           req,
	dlct_rsp_if.source                         rsp
);
	dlct_pkg::cfg_t       cfg_q;
	dlct_pkg::item_t      req_item;
	dlct_pkg::upd_t       upd;
	dlct_pkg::keg_state_t cur;
	dlct_pkg::arc_entry_t arc_rdata;
	dlct_pkg::result_t    res_s2;

	logic [dlct_pkg::NumKegs-1:0] kvalid_q;
	logic [dlct_pkg::KegStW-1:0]  keg_rdata;
	logic [dlct_pkg::ArcW-1:0]    arc_rdata_raw;

	logic                 s1_valid_q;
	dlct_pkg::item_t      s1_item_q;
	logic                 s1_fwd_q;
	dlct_pkg::keg_state_t s1_fwd_state_q;

	logic                   s2_valid_q;
	logic                   s2_in_range_s2;
	dlct_pkg::keg_state_t   s2_state_s2;
	logic [dlct_pkg::LevelW-1:0] s2_level_s2;
	logic                   s2_archived_s2;
	dlct_pkg::arc_entry_t   s2_arc_s2;
	logic                   s2_rec_valid_s2;

	logic              rsp_valid_q;
	dlct_pkg::result_t rsp_q;

	logic out_free;
	logic s2_free;
	logic s1_free;
	logic s1_adv;
	logic accept;
	logic st_we;
	logic arc_we;
	logic arc_re;

	assign req_item = '{action: req.action, keg_index: req.keg_index, level_cl: req.level_cl,
		weight_g: req.weight_g, empty_weight_g: req.empty_weight_g, scale_ok: req.scale_ok,
		day_number: req.day_number, position: req.position};

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign s2_free   = !s2_valid_q || out_free;
	assign s1_adv    = s1_valid_q && s2_free;
	assign s1_free   = !s1_valid_q || s2_free;
	assign req.ready = s1_free;
	assign accept    = req.valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_tolerance_cl  <= dlct_pkg::NoiseW'(20);
			cfg_q.removal_drop_cl     <= dlct_pkg::RemW'(200);
			cfg_q.return_tolerance_cl <= dlct_pkg::RetW'(30);
			cfg_q.rise_hysteresis_cl  <= dlct_pkg::HystW'(5);
			cfg_q.weight_margin_g     <= dlct_pkg::MarginW'(200);
		end else if (cfg_we) begin
			case (cfg_index)
				dlct_pkg::RegNoise:  cfg_q.noise_tolerance_cl  <= cfg_wdata[dlct_pkg::NoiseW-1:0];
				dlct_pkg::RegRemove: cfg_q.removal_drop_cl     <= cfg_wdata[dlct_pkg::RemW-1:0];
				dlct_pkg::RegReturn: cfg_q.return_tolerance_cl <= cfg_wdata[dlct_pkg::RetW-1:0];
				dlct_pkg::RegHyst:   cfg_q.rise_hysteresis_cl  <= cfg_wdata[dlct_pkg::HystW-1:0];
				dlct_pkg::RegMargin: cfg_q.weight_margin_g     <= cfg_wdata[dlct_pkg::MarginW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cur = s1_fwd_q ? s1_fwd_state_q :
		(kvalid_q[s1_item_q.keg_index] ? dlct_pkg::keg_state_t'(keg_rdata) : '0);

	dlct_keg_update u_update (
		.item (s1_item_q),
		.cur  (cur),
		.cfg  (cfg_q),
		.upd  (upd)
	);

	assign st_we  = s1_adv && upd.in_range;
	assign arc_we = s1_adv && upd.arc_we;
	assign arc_re = s1_adv && upd.arc_re;

	dlct_ram #(.WIDTH(dlct_pkg::KegStW), .DEPTH(dlct_pkg::NumKegs)) u_keg_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (s1_item_q.keg_index),
		.wdata (upd.next),
		.re    (accept),
		.raddr (req.keg_index),
		.rdata (keg_rdata)
	);

	dlct_ram #(.WIDTH(dlct_pkg::ArcW), .DEPTH(dlct_pkg::ArchDepth)) u_arc_ram (
		.clk   (clk),
		.we    (arc_we),
		.waddr (upd.arc_addr),
		.wdata (upd.arc_wdata),
		.re    (arc_re),
		.raddr (upd.arc_addr),
		.rdata (arc_rdata_raw)
	);

	assign arc_rdata = dlct_pkg::arc_entry_t'(arc_rdata_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kvalid_q    <= '0;
			s1_valid_q  <= 1'b0;
			s1_fwd_q    <= 1'b0;
			s2_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (st_we) begin
				kvalid_q[s1_item_q.keg_index] <= 1'b1;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
				s1_fwd_q   <= s1_adv && (s1_item_q.keg_index == req.keg_index);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
				s1_fwd_q   <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (out_free) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_valid_q && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item_q      <= req_item;
			s1_fwd_state_q <= upd.next;
		end
		if (s1_adv) begin
			s2_in_range_s2  <= upd.in_range;
			s2_state_s2     <= upd.next;
			s2_level_s2     <= s1_item_q.level_cl;
			s2_archived_s2  <= upd.archived;
			s2_arc_s2       <= upd.arc_wdata;
			s2_rec_valid_s2 <= upd.arc_re;
		end
		if (s2_valid_q && out_free) begin
			rsp_q <= res_s2;
		end
	end

	always_comb begin
		res_s2 = '0;
		if (s2_in_range_s2) begin
			if (s2_state_s2.tracked && !s2_state_s2.suspended) begin
				res_s2.consumption_cl = dlct_pkg::usage_at(s2_state_s2.day_max, s2_level_s2,
					cfg_q.noise_tolerance_cl);
			end
			res_s2.is_suspended   = s2_state_s2.suspended;
			res_s2.is_initialized = s2_state_s2.tracked;
			res_s2.archived       = s2_archived_s2;
			res_s2.history_count  = s2_state_s2.count;
			if (s2_archived_s2) begin
				res_s2.archived_day = s2_arc_s2.day;
				res_s2.archived_cl  = s2_arc_s2.amount;
			end
			if (s2_rec_valid_s2) begin
				res_s2.record_valid = 1'b1;
				res_s2.record_day   = arc_rdata.day;
				res_s2.record_cl    = arc_rdata.amount;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.consumption_cl = rsp_q.consumption_cl;
	assign rsp.is_suspended   = rsp_q.is_suspended;
	assign rsp.is_initialized = rsp_q.is_initialized;
	assign rsp.archived       = rsp_q.archived;
	assign rsp.archived_day   = rsp_q.archived_day;
	assign rsp.archived_cl    = rsp_q.archived_cl;
	assign rsp.history_count  = rsp_q.history_count;
	assign rsp.record_valid   = rsp_q.record_valid;
	assign rsp.record_day     = rsp_q.record_day;
	assign rsp.record_cl      = rsp_q.record_cl;

	// Forwarded state only exists alongside an item in the first stage.
	a_fwd_with_item: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fwd_q |-> s1_valid_q)
		else $error("forwarded state without an item in the first stage");

	a_arc_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(arc_we && arc_re))
		else $error("archive written and read in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.history_count <= dlct_pkg::CntW'(dlct_pkg::HistDepth)))
		else $error("history count beyond ring depth");

	a_state_marked: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |=> kvalid_q[$past(s1_item_q.keg_index)])
		else $error("state write did not mark the container valid");

	a_record_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.record_valid) |-> (rsp_q.archived == 1'b0))
		else $error("record read and archive write reported for one item");
endmodule
`default_nettype wire
